/* hdl/rowol_pkg.sv */
package rowol_pkg;

   // field widths of the item and of the result
   localparam int HANDLE_W      = 32;
   localparam int SIZE_W        = 20;
   localparam int OFFSET_W      = 24;
   localparam int DEPTH_DEFAULT = 10;

   // operation codes carried on func
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_FIND = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_WALK,
      ST_DONE
   } state_type;

   // one stored write record
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   size;
   } record_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic do_add;
      logic start_find;
      logic advance;
      logic step;
      logic load_out;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic count_zero;
      logic hit;
      logic last;
      logic out_free;
   } status_type;

endpackage

/* hdl/rowol_ctrl.sv */
module rowol_ctrl
   import rowol_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == FUNC_ADD) begin
                  cmd.do_add = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  cmd.start_find = 1'b1;
                  state_in       = status.count_zero ? ST_DONE : ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            // first read of the walk is in flight
            cmd.advance = 1'b1;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            cmd.advance = 1'b1;
            cmd.step    = 1'b1;
            if (status.hit || status.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/rowol_dpath.sv */
module rowol_dpath
   import rowol_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [HANDLE_W-1:0] req_record_handle,
   input  logic [SIZE_W-1:0]   req_record_size,
   input  logic [OFFSET_W-1:0] req_char_offset,
   input  cmd_type             cmd,
   output status_type          status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [HANDLE_W-1:0] rsp_hit_handle,
   output logic [SIZE_W-1:0]   rsp_hit_size,
   output logic [SIZE_W-1:0]   rsp_byte_in_record
);

   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DIFF_W = SLOT_W + 1;
   localparam int TOT_W  = SIZE_W + CNT_W;
   localparam int CMP_W  = (TOT_W > OFFSET_W) ? TOT_W : OFFSET_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

   // record store
   record_type ring_ff [DEPTH];
   record_type rd_rec_ff;

   logic [SLOT_W-1:0]   wr_slot_ff,  wr_slot_in;
   logic [SLOT_W-1:0]   old_slot_ff, old_slot_in;
   logic                full_ff,     full_in;
   logic [SLOT_W-1:0]   rd_slot_ff,  rd_slot_in;
   logic [CNT_W-1:0]    remain_ff,   remain_in;
   logic [TOT_W-1:0]    total_ff,    total_in;
   logic [OFFSET_W-1:0] offset_ff,   offset_in;
   logic                res_found_ff,  res_found_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [SIZE_W-1:0]   res_size_ff,   res_size_in;
   logic [SIZE_W-1:0]   res_byte_ff,   res_byte_in;
   logic                rsp_valid_ff,  rsp_valid_in;
   logic                rsp_found_ff,  rsp_found_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [SIZE_W-1:0]   rsp_size_ff,   rsp_size_in;
   logic [SIZE_W-1:0]   rsp_byte_ff,   rsp_byte_in;

   logic [SLOT_W-1:0] next_wr;
   logic [SLOT_W-1:0] next_old;
   logic [SLOT_W-1:0] next_rd;
   logic [DIFF_W-1:0] diff;
   logic [CNT_W-1:0]  count;
   logic [TOT_W-1:0]  sum;
   logic [CMP_W-1:0]  byte_wide;
   logic              hit;

   // memory write on add, registered read at the walk slot
   always_ff @(posedge clock) begin
      if (cmd.do_add) begin
         ring_ff[wr_slot_ff] <= '{handle: req_record_handle, size: req_record_size};
      end
      rd_rec_ff <= ring_ff[rd_slot_ff];
   end

   // slot wrap and count of live records
   always_comb begin
      next_wr  = (wr_slot_ff == LAST_SLOT) ? '0 : wr_slot_ff + 1'b1;
      next_old = (old_slot_ff == LAST_SLOT) ? '0 : old_slot_ff + 1'b1;
      next_rd  = (rd_slot_ff == LAST_SLOT) ? '0 : rd_slot_ff + 1'b1;
      diff     = {1'b0, wr_slot_ff} - {1'b0, old_slot_ff};
      if (wr_slot_ff < old_slot_ff) begin
         diff = diff + DIFF_W'(DEPTH);
      end
      count = full_ff ? CNT_W'(DEPTH) : CNT_W'(diff);
   end

   // running end of the record under walk
   always_comb begin
      sum       = total_ff + TOT_W'(rd_rec_ff.size);
      hit       = CMP_W'(sum) > CMP_W'(offset_ff);
      byte_wide = CMP_W'(offset_ff) - CMP_W'(total_ff);
   end

   // next values of all registers
   always_comb begin
      wr_slot_in    = wr_slot_ff;
      old_slot_in   = old_slot_ff;
      full_in       = full_ff;
      rd_slot_in    = rd_slot_ff;
      remain_in     = remain_ff;
      total_in      = total_ff;
      offset_in     = offset_ff;
      res_found_in  = res_found_ff;
      res_handle_in = res_handle_ff;
      res_size_in   = res_size_ff;
      res_byte_in   = res_byte_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_byte_in   = rsp_byte_ff;

      if (cmd.do_add || cmd.start_find) begin
         res_found_in  = 1'b0;
         res_handle_in = '0;
         res_size_in   = '0;
         res_byte_in   = '0;
      end
      // add: advance write slot, oldest slot follows once full
      if (cmd.do_add) begin
         wr_slot_in  = next_wr;
         old_slot_in = full_ff ? next_old : old_slot_ff;
         full_in     = full_ff || (next_wr == old_slot_in);
      end
      // find: walk starts at the oldest record
      if (cmd.start_find) begin
         rd_slot_in = old_slot_ff;
         remain_in  = count;
         total_in   = '0;
         offset_in  = req_char_offset;
      end
      if (cmd.advance) begin
         rd_slot_in = next_rd;
      end
      // one record per cycle
      if (cmd.step) begin
         total_in  = sum;
         remain_in = remain_ff - 1'b1;
         if (hit) begin
            res_found_in  = 1'b1;
            res_handle_in = rd_rec_ff.handle;
            res_size_in   = rd_rec_ff.size;
            res_byte_in   = byte_wide[SIZE_W-1:0];
         end
      end
      // output register
      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = res_found_ff;
         rsp_handle_in = res_handle_ff;
         rsp_size_in   = res_size_ff;
         rsp_byte_in   = res_byte_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff   <= '0;
         old_slot_ff  <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_slot_ff   <= wr_slot_in;
         old_slot_ff  <= old_slot_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_slot_ff    <= rd_slot_in;
      remain_ff     <= remain_in;
      total_ff      <= total_in;
      offset_ff     <= offset_in;
      res_found_ff  <= res_found_in;
      res_handle_ff <= res_handle_in;
      res_size_ff   <= res_size_in;
      res_byte_ff   <= res_byte_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   // status to the controller
   always_comb begin
      status.count_zero = (count == '0);
      status.hit        = hit;
      status.last       = (remain_ff == CNT_W'(1));
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_hit_handle     = rsp_handle_ff;
   assign rsp_hit_size       = rsp_size_ff;
   assign rsp_byte_in_record = rsp_byte_ff;

   // a full ring keeps both slots together
   assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (wr_slot_ff == old_slot_ff))
      else $error("full ring with split slots");

   // the oldest slot moves only once the ring is full
   assert property (@(posedge clock) disable iff (reset)
      !full_ff |-> (old_slot_ff == '0))
      else $error("oldest slot moved before ring filled");

   // slots stay inside the ring
   assert property (@(posedge clock) disable iff (reset)
      (wr_slot_ff <= LAST_SLOT) && (old_slot_ff <= LAST_SLOT))
      else $error("slot out of range");

   // no result overwritten before it is taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten");

   // a hit lies inside its record
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_byte_ff < rsp_size_ff))
      else $error("byte offset outside hit record");

endmodule

/* hdl/ring_of_writes_offset_lookup.sv */
// add item: record written on acceptance, empty result loaded via the done state, then back to idle
// find item: fetch, then a walk of k records (1 to DEPTH), then done; an empty ring goes straight to done
// the walk reads one record a cycle from the single read port of the record store
// a finished result waits in an output register while the next item is accepted
// synchronous active-high reset empties the ring and drops any pending result
module ring_of_writes_offset_lookup
   import rowol_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [HANDLE_W-1:0] req_record_handle,
   input  logic [SIZE_W-1:0]   req_record_size,
   input  logic [OFFSET_W-1:0] req_char_offset,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [HANDLE_W-1:0] rsp_hit_handle,
   output logic [SIZE_W-1:0]   rsp_hit_size,
   output logic [SIZE_W-1:0]   rsp_byte_in_record
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   rowol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   // record store, walk and output register
   rowol_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_record_handle  (req_record_handle),
      .req_record_size    (req_record_size),
      .req_char_offset    (req_char_offset),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_hit_handle     (rsp_hit_handle),
      .rsp_hit_size       (rsp_hit_size),
      .rsp_byte_in_record (rsp_byte_in_record)
   );

endmodule

/* tb/sv/ring_of_writes_offset_lookup_test.sv */
module ring_of_writes_offset_lookup_test;
   import rowol_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH  = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 2 * (RING_DEPTH + 3) + 4;

   // one lookup result as the block should return it
   typedef struct {
      logic                found;
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   size;
      logic [SIZE_W-1:0]   byte_off;
   } lookup_result_type;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_ready;
   logic                req_func           = FUNC_ADD;
   logic [HANDLE_W-1:0] req_record_handle  = '0;
   logic [SIZE_W-1:0]   req_record_size    = '0;
   logic [OFFSET_W-1:0] req_char_offset    = '0;
   logic                rsp_valid;
   logic                rsp_ready          = 1'b0;
   logic                rsp_found;
   logic [HANDLE_W-1:0] rsp_hit_handle;
   logic [SIZE_W-1:0]   rsp_hit_size;
   logic [SIZE_W-1:0]   rsp_byte_in_record;

   // shadow copy of the record ring
   logic [HANDLE_W-1:0] ring_handle [RING_DEPTH];
   logic [SIZE_W-1:0]   ring_size [RING_DEPTH];
   int unsigned         wr_slot = 0;
   int unsigned         old_slot = 0;
   bit                  is_full = 1'b0;

   lookup_result_type   pending_results[$];
   lookup_result_type   due_result;
   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         stall_pct = 0;

   ring_of_writes_offset_lookup #(
      .DEPTH(RING_DEPTH)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_record_handle  (req_record_handle),
      .req_record_size    (req_record_size),
      .req_char_offset    (req_char_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_hit_handle     (rsp_hit_handle),
      .rsp_hit_size       (rsp_hit_size),
      .rsp_byte_in_record (rsp_byte_in_record)
   );

   // clock
   always #6 clock = ~clock;

   initial begin
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring_handle[i] = '0;
         ring_size[i]   = '0;
      end
   end

   // ring arithmetic
   function automatic int unsigned next_slot(int unsigned s);
      return (s == RING_DEPTH - 1) ? 0 : s + 1;
   endfunction

   function automatic int unsigned live_records();
      return is_full ? RING_DEPTH : (wr_slot + RING_DEPTH - old_slot) % RING_DEPTH;
   endfunction

   // bytes held by the first k live records, oldest first
   function automatic int unsigned span_of(int unsigned k);
      int unsigned slot;
      int unsigned sum;
      slot = old_slot;
      sum  = 0;
      for (int unsigned i = 0; i < k; i++) begin
         sum  += ring_size[slot];
         slot  = next_slot(slot);
      end
      return sum;
   endfunction

   // apply one item to the shadow ring and work out its result
   function automatic lookup_result_type ring_apply(logic func, logic [HANDLE_W-1:0] h,
                                                    logic [SIZE_W-1:0] sz,
                                                    logic [OFFSET_W-1:0] off);
      lookup_result_type r;
      int unsigned       slot;
      int unsigned       run;
      int unsigned       start;
      int unsigned       count;
      r = '{found: 1'b0, handle: '0, size: '0, byte_off: '0};
      if (func == FUNC_ADD) begin
         ring_handle[wr_slot] = h;
         ring_size[wr_slot]   = sz;
         wr_slot = next_slot(wr_slot);
         if (is_full) old_slot = next_slot(old_slot);
         if (wr_slot == old_slot) is_full = 1'b1;
         return r;
      end
      // walk oldest first until the running end passes the offset
      count = live_records();
      slot  = old_slot;
      run   = 0;
      for (int unsigned i = 0; i < count; i++) begin
         start = run;
         run  += ring_size[slot];
         if (run > off) begin
            r.found    = 1'b1;
            r.handle   = ring_handle[slot];
            r.size     = ring_size[slot];
            r.byte_off = SIZE_W'(off - start);
            return r;
         end
         slot = next_slot(slot);
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   // send one item, holding it until the block takes it
   task automatic send_item(logic func, logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] sz,
                            logic [OFFSET_W-1:0] off);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_record_handle <= h;
      req_record_size   <= sz;
      req_char_offset   <= off;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(ring_apply(func, h, sz, off));
   endtask

   task automatic add_record(logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] sz);
      send_item(FUNC_ADD, h, sz, OFFSET_W'($urandom));
   endtask

   task automatic find_offset(logic [OFFSET_W-1:0] off);
      send_item(FUNC_FIND, $urandom, SIZE_W'($urandom), off);
   endtask

   // sender goes quiet until every result is back
   task automatic hold_until_results_in();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // empty ring, zero-size and largest records, offsets at record edges
   task automatic test_directed_edges();
      find_offset('0);
      add_record('1, '0);
      add_record('0, '1);
      add_record(32'h1234_5678, 20'd1);
      find_offset(24'd0);
      find_offset(24'h0F_FFFE);
      find_offset(24'h0F_FFFF);
      find_offset(24'h10_0000);
      find_offset('1);
   endtask

   // fill the ring, overwrite the oldest record, look up around the new ends
   task automatic test_ring_fill_wrap();
      while (!is_full) add_record($urandom, SIZE_W'($urandom_range(300)));
      find_offset(24'd0);
      add_record(32'hA5A5_5A5A, 20'd17);
      find_offset(24'd0);
      find_offset(OFFSET_W'(span_of(live_records()) - 1));
      find_offset(OFFSET_W'(span_of(live_records())));
   endtask

   // mixed adds and finds, finds mostly landing inside the stored bytes
   task automatic test_random_traffic(int unsigned n_items, int unsigned send_pct,
                                      int unsigned stall_in);
      int unsigned         total;
      int unsigned         pick;
      logic [SIZE_W-1:0]   sz;
      logic [OFFSET_W-1:0] off;
      send_idle_pct = send_pct;
      stall_pct     = stall_in;
      for (int unsigned n = 0; n < n_items; n++) begin
         if (n == n_items / 2) hold_until_results_in();
         if ($urandom_range(9) < 5) begin
            pick = $urandom_range(7);
            if (pick == 0)      sz = '0;
            else if (pick < 4)  sz = SIZE_W'($urandom_range(64));
            else if (pick < 6)  sz = SIZE_W'($urandom_range(4095));
            else                sz = SIZE_W'($urandom);
            add_record($urandom, sz);
         end else begin
            total = span_of(live_records());
            pick  = $urandom_range(9);
            if (pick == 6 || total == 0)
               off = OFFSET_W'(total);
            else if (pick == 7)
               off = OFFSET_W'(total - 1);
            else if (pick == 8)
               off = OFFSET_W'($urandom);
            else if (pick == 9)
               off = OFFSET_W'(span_of($urandom_range(live_records() - 1)));
            else
               off = OFFSET_W'($urandom_range(total - 1));
            find_offset(off);
         end
      end
      hold_until_results_in();
   endtask

   // receiver side stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // compare each taken result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no item pending");
         end else begin
            due_result = pending_results.pop_front();
            if (rsp_found !== due_result.found)
               report_mismatch($sformatf("found got %b want %b",
                                         rsp_found, due_result.found));
            if (rsp_hit_handle !== due_result.handle)
               report_mismatch($sformatf("hit_handle got %h want %h",
                                         rsp_hit_handle, due_result.handle));
            if (rsp_hit_size !== due_result.size)
               report_mismatch($sformatf("hit_size got %h want %h",
                                         rsp_hit_size, due_result.size));
            if (rsp_byte_in_record !== due_result.byte_off)
               report_mismatch($sformatf("byte_in_record got %h want %h",
                                         rsp_byte_in_record, due_result.byte_off));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ring_of_writes_offset_lookup regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 0;
      stall_pct     = 0;
      test_directed_edges();
      test_ring_fill_wrap();
      hold_until_results_in();

      test_random_traffic(285, 0, 0);
      test_random_traffic(285, 67, 0);
      test_random_traffic(285, 0, 67);
      test_random_traffic(285, 17, 17);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ring_of_writes_offset_lookup regression: pass");
      else
         $display("ring_of_writes_offset_lookup regression: fail");
      $finish;
   end

endmodule
